// ----- rtl/core/rgc_pkg.sv -----
// Shared types and constants of the grid ray caster.
package rgc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_PX,
    ST_DIV_PY,
    ST_DIV_DX,
    ST_DIV_DY,
    ST_MUL_X,
    ST_MUL_Y,
    ST_START,
    ST_STEP,
    ST_LOOK,
    ST_DONE
  } state_e;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  localparam logic [1:0] REG_PLAYER_X  = 2'd0;
  localparam logic [1:0] REG_PLAYER_Y  = 2'd1;
  localparam logic [1:0] REG_TILE_SIZE = 2'd2;

  localparam logic STATUS_HIT = 1'b0;
  localparam logic STATUS_OUT = 1'b1;
  localparam logic SIDE_X     = 1'b0;
  localparam logic SIDE_Y     = 1'b1;

  localparam int unsigned DIV_NW = 31;
  localparam int unsigned DIV_DW = 17;
  localparam int unsigned DIV_CW = 5;

  localparam logic [DIV_NW-1:0] DELTA_NUM = 31'h4000_0000;
  localparam logic [16:0]       SPAN_ONE  = 17'h1_0000;

endpackage

// ----- rtl/core/dda_grid_ray_traversal.sv -----
// Top level of the grid ray caster: registers, sequencer, DDA stepping.
// A write word sets one map cell. A cast word runs four divisions on one shared
// divider (31 quotient bits each: player x and y over the tile size, then both
// deltas), two multiply steps for the first side distances, one start check,
// then a step and a registered map read per grid cell stepped. A cast ends
// when a wall is hit, when the ray leaves the map, or when the start cell is
// outside the map; a waiting result word holds the sequencer until it drains.
// After reset a clearing pass zeroes the map; no word is taken until it ends,
// configuration writes are taken always.
module dda_grid_ray_traversal #(
  parameter int unsigned MAP_W = 64,
  parameter int unsigned MAP_H = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [19:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // cell_x, cell_y, wall, dir_x, dir_y, zero pad
  input  logic        s_axis_tuser_i,  // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,  // hit_x, hit_y, hit_side, side_dist_x,
                                       // side_dist_y, zero pad
  output logic        m_axis_tuser_o   // status
);

  localparam int unsigned XW = $clog2(MAP_W);
  localparam int unsigned YW = $clog2(MAP_H);
  localparam int unsigned CW = 14;

  rgc_pkg::state_e state_q, state_d;

  logic [19:0] player_x_q, player_y_q;
  logic [6:0]  tile_q;
  logic [15:0] dir_x_q, dir_y_q;
  logic [27:0] px_q, py_q;
  logic [31:0] dx_q, dy_q, sx_q, sy_q;
  logic signed [CW-1:0] mx_q, my_q;
  logic        res_status_q, res_side_q;
  logic [5:0]  res_hx_q, res_hy_q;
  logic        m_valid_q;
  logic [79:0] m_data_q;
  logic        m_user_q;

  logic        clearing;
  logic        s_fire, cast_fire, write_fire;
  logic [5:0]  in_cx, in_cy;
  logic [8:0]  cx_ext, cy_ext;
  logic        wr_en;
  logic        map_rd;

  logic        div_start, div_done;
  logic [rgc_pkg::DIV_NW-1:0] div_num, div_q;
  logic [rgc_pkg::DIV_DW-1:0] div_den;
  logic [6:0]  tile_eff;
  logic [16:0] mag_x, mag_y;
  logic [31:0] delta;

  logic [15:0] mul_frac;
  logic        mul_neg;
  logic [31:0] mul_delta;
  logic [16:0] span;
  logic [48:0] prod;
  logic [31:0] prod_sat;

  logic        step_x;
  logic [32:0] sum;
  logic [31:0] sum_sat;
  logic signed [CW-1:0] nx, ny;
  logic        off_map, start_off;
  logic        out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q <= '0;
      player_y_q <= '0;
      tile_q     <= 7'd32;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        rgc_pkg::REG_PLAYER_X:  player_x_q <= cfg_data_i;
        rgc_pkg::REG_PLAYER_Y:  player_y_q <= cfg_data_i;
        rgc_pkg::REG_TILE_SIZE: tile_q     <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == rgc_pkg::ST_IDLE) && !clearing;
  assign s_fire     = s_axis_tvalid_i && s_axis_tready_o;
  assign cast_fire  = s_fire && (s_axis_tuser_i == rgc_pkg::ACT_CAST);
  assign write_fire = s_fire && (s_axis_tuser_i == rgc_pkg::ACT_WRITE);
  assign in_cx  = s_axis_tdata_i[5:0];
  assign in_cy  = s_axis_tdata_i[11:6];
  assign cx_ext = {3'b000, in_cx};
  assign cy_ext = {3'b000, in_cy};
  assign wr_en  = write_fire && (cx_ext < 9'(MAP_W)) && (cy_ext < 9'(MAP_H));

  rgc_map #(.XW(XW), .YW(YW)) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  ({cy_ext[YW-1:0], cx_ext[XW-1:0]}),
    .wr_data_i  (s_axis_tdata_i[12]),
    .rd_addr_i  ({ny[YW-1:0], nx[XW-1:0]}),
    .rd_data_o  (map_rd),
    .clearing_o (clearing)
  );

  always_comb begin
    tile_eff = (tile_q == 7'd0) ? 7'd1 : tile_q;
    mag_x = dir_x_q[15] ? (rgc_pkg::SPAN_ONE - {1'b0, dir_x_q}) : {1'b0, dir_x_q};
    mag_y = dir_y_q[15] ? (rgc_pkg::SPAN_ONE - {1'b0, dir_y_q}) : {1'b0, dir_y_q};
    div_num   = {3'b000, player_x_q, 8'h00};
    div_den   = {10'd0, tile_eff};
    div_start = 1'b0;
    unique case (state_q)
      rgc_pkg::ST_IDLE: begin
        div_start = cast_fire;
      end
      rgc_pkg::ST_DIV_PX: begin
        div_num   = {3'b000, player_y_q, 8'h00};
        div_start = div_done;
      end
      rgc_pkg::ST_DIV_PY: begin
        div_num   = rgc_pkg::DELTA_NUM;
        div_den   = mag_x;
        div_start = div_done;
      end
      rgc_pkg::ST_DIV_DX: begin
        div_num   = rgc_pkg::DELTA_NUM;
        div_den   = mag_y;
        div_start = div_done;
      end
      default: ;
    endcase
  end

  rgc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    if (state_q == rgc_pkg::ST_DIV_DX) begin
      delta = (mag_x == 17'd0) ? '1 : {1'b0, div_q};
    end else begin
      delta = (mag_y == 17'd0) ? '1 : {1'b0, div_q};
    end
    if (state_q == rgc_pkg::ST_MUL_X) begin
      mul_frac  = px_q[15:0];
      mul_neg   = dir_x_q[15];
      mul_delta = dx_q;
    end else begin
      mul_frac  = py_q[15:0];
      mul_neg   = dir_y_q[15];
      mul_delta = dy_q;
    end
    span     = mul_neg ? {1'b0, mul_frac} : (rgc_pkg::SPAN_ONE - {1'b0, mul_frac});
    prod     = span * mul_delta;
    prod_sat = prod[48] ? '1 : prod[47:16];

    step_x  = sx_q < sy_q;
    sum     = step_x ? ({1'b0, sx_q} + {1'b0, dx_q}) : ({1'b0, sy_q} + {1'b0, dy_q});
    sum_sat = sum[32] ? '1 : sum[31:0];
    nx = mx_q;
    ny = my_q;
    if (step_x) begin
      nx = dir_x_q[15] ? (mx_q - CW'(1)) : (mx_q + CW'(1));
    end else begin
      ny = dir_y_q[15] ? (my_q - CW'(1)) : (my_q + CW'(1));
    end
    off_map   = (nx < 0) || (ny < 0) || (nx >= $signed(CW'(MAP_W)))
             || (ny >= $signed(CW'(MAP_H)));
    start_off = (mx_q >= $signed(CW'(MAP_W))) || (my_q >= $signed(CW'(MAP_H)));
    out_free  = !m_valid_q || m_axis_tready_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rgc_pkg::ST_IDLE:   if (cast_fire) state_d = rgc_pkg::ST_DIV_PX;
      rgc_pkg::ST_DIV_PX: if (div_done) state_d = rgc_pkg::ST_DIV_PY;
      rgc_pkg::ST_DIV_PY: if (div_done) state_d = rgc_pkg::ST_DIV_DX;
      rgc_pkg::ST_DIV_DX: if (div_done) state_d = rgc_pkg::ST_DIV_DY;
      rgc_pkg::ST_DIV_DY: if (div_done) state_d = rgc_pkg::ST_MUL_X;
      rgc_pkg::ST_MUL_X:  state_d = rgc_pkg::ST_MUL_Y;
      rgc_pkg::ST_MUL_Y:  state_d = rgc_pkg::ST_START;
      rgc_pkg::ST_START:  state_d = start_off ? rgc_pkg::ST_DONE : rgc_pkg::ST_STEP;
      rgc_pkg::ST_STEP:   state_d = off_map ? rgc_pkg::ST_DONE : rgc_pkg::ST_LOOK;
      rgc_pkg::ST_LOOK:   state_d = map_rd ? rgc_pkg::ST_DONE : rgc_pkg::ST_STEP;
      rgc_pkg::ST_DONE:   if (out_free) state_d = rgc_pkg::ST_IDLE;
      default:            state_d = rgc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rgc_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rgc_pkg::ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rgc_pkg::ST_IDLE: begin
        if (cast_fire) begin
          dir_x_q <= s_axis_tdata_i[28:13];
          dir_y_q <= s_axis_tdata_i[44:29];
        end
      end
      rgc_pkg::ST_DIV_PX: if (div_done) px_q <= div_q[27:0];
      rgc_pkg::ST_DIV_PY: if (div_done) py_q <= div_q[27:0];
      rgc_pkg::ST_DIV_DX: if (div_done) dx_q <= delta;
      rgc_pkg::ST_DIV_DY: if (div_done) dy_q <= delta;
      rgc_pkg::ST_MUL_X: begin
        sx_q <= prod_sat;
        mx_q <= {2'b00, px_q[27:16]};
        my_q <= {2'b00, py_q[27:16]};
      end
      rgc_pkg::ST_MUL_Y: begin
        sy_q <= prod_sat;
      end
      rgc_pkg::ST_START: begin
        res_status_q <= rgc_pkg::STATUS_OUT;
        res_side_q   <= rgc_pkg::SIDE_X;
        res_hx_q     <= '0;
        res_hy_q     <= '0;
      end
      rgc_pkg::ST_STEP: begin
        if (step_x) begin
          sx_q <= sum_sat;
        end else begin
          sy_q <= sum_sat;
        end
        mx_q         <= nx;
        my_q         <= ny;
        res_side_q   <= off_map ? rgc_pkg::SIDE_X : (step_x ? rgc_pkg::SIDE_X : rgc_pkg::SIDE_Y);
        res_status_q <= off_map ? rgc_pkg::STATUS_OUT : rgc_pkg::STATUS_HIT;
      end
      rgc_pkg::ST_LOOK: begin
        res_hx_q <= mx_q[5:0];
        res_hy_q <= my_q[5:0];
      end
      rgc_pkg::ST_DONE: begin
        if (out_free) begin
          m_user_q <= res_status_q;
          m_data_q <= {3'b000, sy_q, sx_q, res_side_q,
                       (res_status_q == rgc_pkg::STATUS_OUT) ? 6'd0 : res_hy_q,
                       (res_status_q == rgc_pkg::STATUS_OUT) ? 6'd0 : res_hx_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

// ----- rtl/core/rgc_div.sv -----
// Restoring divider, one quotient bit per cycle.
module rgc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rgc_pkg::DIV_NW-1:0]      dividend_i,
  input  logic [rgc_pkg::DIV_DW-1:0]      divisor_i,
  output logic                            done_o,
  output logic [rgc_pkg::DIV_NW-1:0]      quotient_o
);

  logic                       busy_q;
  logic                       done_q;
  logic [rgc_pkg::DIV_CW-1:0] cnt_q;
  logic [rgc_pkg::DIV_NW-1:0] quo_q;
  logic [rgc_pkg::DIV_DW:0]   rem_q;
  logic [rgc_pkg::DIV_DW-1:0] dvs_q;
  logic [rgc_pkg::DIV_DW:0]   rem_sh;
  logic [rgc_pkg::DIV_DW:0]   rem_d;
  logic                       ge;

  always_comb begin
    rem_sh = {rem_q[rgc_pkg::DIV_DW-1:0], quo_q[rgc_pkg::DIV_NW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= rgc_pkg::DIV_CW'(rgc_pkg::DIV_NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rgc_pkg::DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[rgc_pkg::DIV_NW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/core/rgc_map.sv -----
// Wall bitmap memory with a clearing pass after reset.
module rgc_map #(
  parameter int unsigned XW = 6,
  parameter int unsigned YW = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [XW+YW-1:0]    wr_addr_i,
  input  logic                wr_data_i,
  input  logic [XW+YW-1:0]    rd_addr_i,
  output logic                rd_data_o,
  output logic                clearing_o
);

  localparam int unsigned AW    = XW + YW;
  localparam int unsigned DEPTH = 1 << AW;

  logic             mem [DEPTH];
  logic             clr_q;
  logic [AW-1:0]    clr_cnt_q;
  logic             rd_q;
  logic             we;
  logic [AW-1:0]    waddr;
  logic             wdata;

  always_comb begin
    we    = clr_q | wr_en_i;
    waddr = clr_q ? clr_cnt_q : wr_addr_i;
    wdata = clr_q ? 1'b0 : wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == {AW{1'b1}}) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o  = rd_q;
  assign clearing_o = clr_q;

endmodule
